>>> rtl/u8cd_pkg.sv
// constants, result word type and lead byte helpers for the utf-8 codepoint decoder
// no dependencies; imported by utf8_codepoint_decoder
package u8cd_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TDATA_W = 24;

    // lead byte patterns
    localparam logic [7:0] MASK_1B = 8'h80;
    localparam logic [7:0] MASK_2B = 8'hE0;
    localparam logic [7:0] LEAD_2B = 8'hC0;
    localparam logic [7:0] MASK_3B = 8'hF0;
    localparam logic [7:0] LEAD_3B = 8'hE0;
    localparam logic [7:0] MASK_4B = 8'hF8;
    localparam logic [7:0] LEAD_4B = 8'hF0;

    // sequence lengths, zero for a byte that cannot lead
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_1    = 3'd1;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    // one queued entry: one or two results caused by a single input word
    typedef struct packed {
        logic [CP_W-1:0] cp0;
        logic [CP_W-1:0] cp1;
        logic            two;
        logic            has;
        logic            eos;
    } t_res_entry;

    // sequence length set by a lead byte
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] len;
        if ((b & MASK_1B) == 8'h00)        len = LEN_1;
        else if ((b & MASK_2B) == LEAD_2B) len = LEN_2;
        else if ((b & MASK_3B) == LEAD_3B) len = LEN_3;
        else if ((b & MASK_4B) == LEAD_4B) len = LEN_4;
        else                               len = LEN_NONE;
        return len;
    endfunction

    // join payload bits of a sequence of n bytes, continuation bits unchecked
    function automatic logic [CP_W-1:0] join_seq(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3,
        input logic [2:0] n
    );
        logic [CP_W-1:0] v;
        unique case (n)
            LEN_1:   v = {13'd0, b0};
            LEN_2:   v = {10'd0, b0[4:0], b1[5:0]};
            LEN_3:   v = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            LEN_4:   v = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/utf8_codepoint_decoder.sv
// utf-8 codepoint decoder top level: byte stream in, codepoint stream out
// depends on u8cd_pkg
//
// Usage
//   slave channel: one string byte per word in s_axis_tdata[7:0], s_axis_tlast on the
//   final byte of a string. master channel: codepoint in m_axis_tdata[20:0],
//   m_axis_tuser = has codepoint (0 for a bare end marker), m_axis_tlast on the final
//   result caused by the last byte of a string.
//   Decode is done in the accept cycle from the held bytes and the new byte; the
//   results are registered into a two-entry result queue that drives the master
//   port. Throughput is one byte per cycle while the queue has room; a truncated
//   tail that yields two codepoints is sent as two words from the single result
//   port. Bytes that complete nothing produce no word.
//   When the receiver stalls the queue fills and s_axis_tready drops once both
//   entries are occupied; no word is lost or repeated.
//   Reset (synchronous, active low) empties the queue and drops any partial sequence.
module utf8_codepoint_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slave side
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] data_byte
    input  logic                         s_axis_tlast,   // last_byte
    // master side
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [u8cd_pkg::TDATA_W-1:0] m_axis_tdata,   // [20:0] codepoint, zero pad
    output logic [0:0]                   m_axis_tuser,   // [0] has_codepoint
    output logic                         m_axis_tlast    // end_of_string
);
    import u8cd_pkg::*;

    // held partial sequence
    logic [7:0] r_h0, r_h1, r_h2;
    logic [7:0] n_h0, n_h1, n_h2;
    logic [1:0] r_hc, n_hc;

    // result queue
    t_res_entry r_fifo [2];
    logic       r_wptr, r_rptr, r_sub;
    logic [1:0] r_cnt;

    logic       in_acc, out_take, do_pop;
    logic       push;
    t_res_entry push_ent;
    t_res_entry head;

    // decode signals
    logic [7:0]      buf0, buf1, buf2, buf3;
    logic [2:0]      need, tail_len;
    logic            full;
    logic [CP_W-1:0] cp_full, cp_a, cp_b;
    logic            v_a, v_b, b_ascii;

    assign s_axis_tready = (r_cnt != 2'd2);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // line up held bytes and the new byte as one sequence
    always_comb begin
        buf0 = (r_hc == 2'd0) ? s_axis_tdata : r_h0;
        buf1 = (r_hc == 2'd1) ? s_axis_tdata : r_h1;
        buf2 = (r_hc == 2'd2) ? s_axis_tdata : r_h2;
        buf3 = s_axis_tdata;
        need    = seq_len(buf0);
        full    = (need != LEN_NONE) && (need == ({1'b0, r_hc} + 3'd1));
        cp_full = join_seq(buf0, buf1, buf2, buf3, need);
    end

    // truncated tail at string end: lead dropped, rest decoded again
    always_comb begin
        b_ascii  = (s_axis_tdata[7] == 1'b0) && (s_axis_tdata != 8'h00);
        tail_len = seq_len(r_h1);
        cp_a     = '0;
        v_a      = 1'b0;
        cp_b     = {13'd0, s_axis_tdata};
        v_b      = 1'b0;
        if (r_hc == 2'd1) begin
            v_b = b_ascii;
        end else if (r_hc == 2'd2) begin
            if (tail_len == LEN_2) begin
                cp_a = join_seq(r_h1, s_axis_tdata, 8'h00, 8'h00, LEN_2);
                v_a  = (cp_a != '0);
            end else begin
                cp_a = {13'd0, r_h1};
                v_a  = (tail_len == LEN_1) && (r_h1 != 8'h00);
                v_b  = b_ascii;
            end
        end
    end

    // next held state and the entry to queue
    always_comb begin
        n_h0     = r_h0;
        n_h1     = r_h1;
        n_h2     = r_h2;
        n_hc     = r_hc;
        push     = 1'b0;
        push_ent = '{cp0: '0, cp1: '0, two: 1'b0, has: 1'b0, eos: 1'b0};
        if (s_axis_tlast) begin
            n_hc = 2'd0;
            push = 1'b1;
            push_ent.eos = 1'b1;
            if (full) begin
                push_ent.cp0 = cp_full;
                push_ent.has = (cp_full != '0);
            end else if (v_a && v_b) begin
                push_ent.cp0 = cp_a;
                push_ent.cp1 = cp_b;
                push_ent.two = 1'b1;
                push_ent.has = 1'b1;
            end else if (v_a) begin
                push_ent.cp0 = cp_a;
                push_ent.has = 1'b1;
            end else if (v_b) begin
                push_ent.cp0 = cp_b;
                push_ent.has = 1'b1;
            end
        end else if (full) begin
            n_hc         = 2'd0;
            push         = (cp_full != '0);
            push_ent.cp0 = cp_full;
            push_ent.has = 1'b1;
        end else if (need == LEN_NONE) begin
            n_hc = 2'd0;
        end else begin
            // store the byte behind the ones already held
            unique case (r_hc)
                2'd0:    n_h0 = s_axis_tdata;
                2'd1:    n_h1 = s_axis_tdata;
                default: n_h2 = s_axis_tdata;
            endcase
            n_hc = r_hc + 2'd1;
        end
    end

    // held state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc <= 2'd0;
        end else if (in_acc) begin
            r_hc <= n_hc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_h0 <= n_h0;
            r_h1 <= n_h1;
            r_h2 <= n_h2;
        end
    end

    // result queue output side
    assign head          = r_fifo[r_rptr];
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign out_take      = m_axis_tvalid && m_axis_tready;
    assign do_pop        = out_take && !(head.two && !r_sub);

    always_comb begin
        if (head.two && !r_sub) begin
            m_axis_tdata = {{(TDATA_W-CP_W){1'b0}}, head.cp0};
            m_axis_tuser = 1'b1;
            m_axis_tlast = 1'b0;
        end else begin
            m_axis_tdata = {{(TDATA_W-CP_W){1'b0}}, head.two ? head.cp1 : head.cp0};
            m_axis_tuser = head.has;
            m_axis_tlast = head.eos;
        end
    end

    // result queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_sub  <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (in_acc && push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
                r_sub  <= 1'b0;
            end else if (out_take) begin
                r_sub <= 1'b1;
            end
            r_cnt <= r_cnt + {1'b0, in_acc && push} - {1'b0, do_pop};
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (in_acc && push) begin
            r_fifo[r_wptr] <= push_ent;
        end
    end

endmodule
